>>> sv/led_driver_two_wire_display_writer_assert.svh
// Assertion macros shared by the display writer modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef LED_DRIVER_TWO_WIRE_DISPLAY_WRITER_ASSERT_SVH
`define LED_DRIVER_TWO_WIRE_DISPLAY_WRITER_ASSERT_SVH

// Condition holds at every edge out of reset.
`define LDDW_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// Consequence holds in the same cycle as the antecedent.
`define LDDW_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// Consequence holds in the cycle after the antecedent.
`define LDDW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

>>> sv/lddw_pkg.sv
package lddw_pkg;

  // Depth of the queue between front and back; also the credit count.
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Zero bytes written by a clear request after the start address.
  localparam int CLEAR_BYTES = 16;

  localparam logic [13:0] NUM_CAP    = 14'd9999;
  localparam logic [7:0]  DP_BIT     = 8'h80;
  localparam logic [7:0]  CLEAR_ADDR = 8'hc0;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SHOW  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_FIXED_MODE  = 3'd0,
    REG_AUTO_MODE   = 3'd1,
    REG_DISPLAY_ON  = 3'd2,
    REG_DISPLAY_OFF = 3'd3,
    REG_DIGIT1_ADDR = 3'd4,
    REG_DIGIT2_ADDR = 3'd5,
    REG_DIGIT3_ADDR = 3'd6,
    REG_DIGIT4_ADDR = 3'd7
  } reg_index_t;

  // Classified request: for show-number the four segment bytes,
  // for write-byte the address in byte 0 and the value in byte 1.
  typedef struct packed {
    action_t          action;
    logic [3:0][7:0]  data;
  } entry_t;

  // Seven-segment pattern of one decimal digit.
  function automatic logic [7:0] seg_code(logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h18;
      4'd2:    code = 8'h76;
      4'd3:    code = 8'h7c;
      4'd4:    code = 8'h59;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h6f;
      4'd7:    code = 8'h38;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h79;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

>>> sv/lddw_queue.sv
`include "led_driver_two_wire_display_writer_assert.svh"

module lddw_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  lddw_pkg::entry_t  wr_entry,
  input  logic              rd_en,
  output logic              empty,
  output lddw_pkg::entry_t  rd_entry
);

  lddw_pkg::entry_t                   slots [lddw_pkg::QDEPTH];
  logic [lddw_pkg::QPTR_W-1:0]        wr_ptr;
  logic [lddw_pkg::QPTR_W-1:0]        rd_ptr;
  logic [lddw_pkg::QCNT_W-1:0]        count;

  // Store incoming requests
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  `LDDW_ASSERT_IMPLY(a_no_underflow, rd_en, !empty)
  `LDDW_ASSERT_IMPLY(a_no_overflow, wr_en && !rd_en, count < lddw_pkg::QCNT_W'(lddw_pkg::QDEPTH))
  `LDDW_ASSERT_ALWAYS(a_count_range, count <= lddw_pkg::QCNT_W'(lddw_pkg::QDEPTH))

endmodule

>>> sv/lddw_front.sv
`include "led_driver_two_wire_display_writer_assert.svh"

module lddw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        action,
  input  logic [15:0]       number,
  input  logic [7:0]        target_addr,
  input  logic [7:0]        seg_value,
  input  logic              deq,
  output logic              q_wr,
  output lddw_pkg::entry_t  q_entry
);

  // Largest k in 0..9 with k * weight not above value.
  function automatic logic [3:0] lead_digit(logic [13:0] value, logic [13:0] weight);
    logic [3:0] digit;
    digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (value >= 14'(k) * weight) begin
        digit = 4'(k);
      end
    end
    return digit;
  endfunction

  logic                         accept;
  logic [lddw_pkg::QCNT_W-1:0]  inflight;
  logic [13:0]                  clamped;
  logic [3:0]                   thou_digit;
  logic [13:0]                  thou_rest;
  logic [3:0]                   hund_digit;
  logic [13:0]                  hund_rest;
  logic [3:0]                   tens_digit;
  logic [13:0]                  tens_rest;

  // Stage 1: thousands digit split off
  logic                         s1_valid;
  lddw_pkg::action_t            s1_action;
  logic [3:0]                   s1_thou;
  logic [9:0]                   s1_rest;
  logic [7:0]                   s1_addr;
  logic [7:0]                   s1_value;

  // Stage 2: hundreds digit split off
  logic                         s2_valid;
  lddw_pkg::action_t            s2_action;
  logic [3:0]                   s2_thou;
  logic [3:0]                   s2_hund;
  logic [6:0]                   s2_rest;
  logic [7:0]                   s2_addr;
  logic [7:0]                   s2_value;

  assign accept = push && !full;
  assign full   = (inflight == lddw_pkg::QCNT_W'(lddw_pkg::QDEPTH));

  // Count requests between input and back end; the queue always has room
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({accept, deq})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  // Clamp and take the thousands digit
  always_comb begin
    clamped    = (number > {2'b00, lddw_pkg::NUM_CAP}) ? lddw_pkg::NUM_CAP : number[13:0];
    thou_digit = lead_digit(clamped, 14'd1000);
    thou_rest  = clamped - 14'({10'd0, thou_digit} * 14'd1000);
  end

  // Hundreds digit of the remainder
  always_comb begin
    hund_digit = lead_digit({4'd0, s1_rest}, 14'd100);
    hund_rest  = {4'd0, s1_rest} - 14'({10'd0, hund_digit} * 14'd100);
  end

  // Tens and units of the remainder
  always_comb begin
    tens_digit = lead_digit({7'd0, s2_rest}, 14'd10);
    tens_rest  = {7'd0, s2_rest} - 14'({10'd0, tens_digit} * 14'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // Payload stages hold no reset
  always_ff @(posedge clk) begin
    s1_action <= lddw_pkg::action_t'(action);
    s1_thou   <= thou_digit;
    s1_rest   <= thou_rest[9:0];
    s1_addr   <= target_addr;
    s1_value  <= seg_value;
    s2_action <= s1_action;
    s2_thou   <= s1_thou;
    s2_hund   <= hund_digit;
    s2_rest   <= hund_rest[6:0];
    s2_addr   <= s1_addr;
    s2_value  <= s1_value;
  end

  // Build the queue entry for the back end
  always_comb begin
    q_wr           = s2_valid;
    q_entry.action = s2_action;
    if (s2_action == lddw_pkg::ACT_SHOW) begin
      q_entry.data[0] = lddw_pkg::seg_code(s2_thou) | lddw_pkg::DP_BIT;
      q_entry.data[1] = lddw_pkg::seg_code(s2_hund) | lddw_pkg::DP_BIT;
      q_entry.data[2] = lddw_pkg::seg_code(tens_digit);
      q_entry.data[3] = lddw_pkg::seg_code(tens_rest[3:0]);
    end else begin
      q_entry.data[0] = s2_addr;
      q_entry.data[1] = s2_value;
      q_entry.data[2] = 8'h00;
      q_entry.data[3] = 8'h00;
    end
  end

  `LDDW_ASSERT_ALWAYS(a_credit_range, inflight <= lddw_pkg::QCNT_W'(lddw_pkg::QDEPTH))
  `LDDW_ASSERT_NEXT(a_pipe_flows, s1_valid, s2_valid)
  `LDDW_ASSERT_IMPLY(a_credit_held, s2_valid, inflight != '0)

endmodule

>>> sv/lddw_back.sv
`include "led_driver_two_wire_display_writer_assert.svh"

module lddw_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              q_empty,
  input  lddw_pkg::entry_t  q_entry,
  output logic              q_rd,
  input  logic              pop,
  output logic              empty,
  output logic              clk_out,
  output logic              data_out,
  output logic              busy_res,
  output logic              rejected,
  output logic              seq_done
);

  // Configuration registers
  logic [7:0]         fixed_mode_cmd;
  logic [7:0]         auto_mode_cmd;
  logic [7:0]         display_on_cmd;
  logic [7:0]         display_off_cmd;
  logic [3:0][7:0]    digit_addr;

  // Sequencer state
  lddw_pkg::action_t  job_kind;
  logic [2:0]         frame_index;
  logic [4:0]         byte_index;
  logic [4:0]         phase_count;
  logic [1:0]         bit_step;
  logic [7:0]         shift_byte;
  logic [3:0][7:0]    digit_segments;
  logic [7:0]         held_addr;
  logic [7:0]         held_value;
  logic               clk_level;
  logic               data_level;
  logic               busy_flag;
  logic               out_valid;

  lddw_pkg::action_t  job_kind_next;
  logic [2:0]         frame_index_next;
  logic [4:0]         byte_index_next;
  logic [4:0]         phase_count_next;
  logic [1:0]         bit_step_next;
  logic [7:0]         shift_byte_next;
  logic               clk_level_next;
  logic               data_level_next;
  logic               busy_flag_next;
  logic               rejected_next;
  logic               done_next;
  logic               start;

  logic [2:0]         frame_total;
  logic               last_frame;
  logic [4:0]         bytes_in_frame;
  logic [1:0]         digit_sel;
  logic [7:0]         frame_byte;
  logic [4:0]         seg_len;
  logic [4:0]         phase_inc;
  logic [4:0]         byte_inc;
  logic [2:0]         frame_inc;

  // Take a request when one waits and the result slot frees up
  assign q_rd  = !q_empty && (!out_valid || pop);
  assign start = q_rd && !busy_flag && (q_entry.action != lddw_pkg::ACT_TICK);

  // Frame geometry of the running job
  always_comb begin
    frame_total = (job_kind == lddw_pkg::ACT_SHOW) ? 3'd6 : 3'd3;
    last_frame  = ({1'b0, frame_index} + 4'd1) >= {1'b0, frame_total};
    if (frame_index == 3'd0 || last_frame) begin
      bytes_in_frame = 5'd1;
    end else if (job_kind == lddw_pkg::ACT_CLEAR) begin
      bytes_in_frame = 5'(1 + lddw_pkg::CLEAR_BYTES);
    end else begin
      bytes_in_frame = 5'd2;
    end
  end

  // Select the byte to shift out next
  always_comb begin
    digit_sel = 2'(frame_index - 3'd1);
    if (frame_index == 3'd0) begin
      frame_byte = (job_kind == lddw_pkg::ACT_CLEAR) ? auto_mode_cmd : fixed_mode_cmd;
    end else if (last_frame) begin
      frame_byte = (job_kind == lddw_pkg::ACT_CLEAR) ? display_off_cmd : display_on_cmd;
    end else if (job_kind == lddw_pkg::ACT_SHOW) begin
      frame_byte = (byte_index == 5'd1) ? digit_addr[digit_sel] : digit_segments[digit_sel];
    end else if (job_kind == lddw_pkg::ACT_WRITE) begin
      frame_byte = (byte_index == 5'd1) ? held_addr : held_value;
    end else begin
      frame_byte = (byte_index == 5'd1) ? lddw_pkg::CLEAR_ADDR : 8'h00;
    end
  end

  // Next state: start a job, or advance one pin phase
  always_comb begin
    job_kind_next    = job_kind;
    frame_index_next = frame_index;
    byte_index_next  = byte_index;
    phase_count_next = phase_count;
    bit_step_next    = bit_step;
    shift_byte_next  = shift_byte;
    clk_level_next   = clk_level;
    data_level_next  = data_level;
    busy_flag_next   = busy_flag;
    rejected_next    = 1'b0;
    done_next        = 1'b0;
    seg_len          = 5'd4;
    phase_inc        = phase_count + 5'd1;
    byte_inc         = byte_index + 5'd1;
    frame_inc        = frame_index + 3'd1;

    if (start) begin
      job_kind_next    = q_entry.action;
      frame_index_next = 3'd0;
      byte_index_next  = 5'd0;
      phase_count_next = 5'd0;
      bit_step_next    = 2'd0;
      busy_flag_next   = 1'b1;
    end else if (q_rd && busy_flag) begin
      rejected_next = (q_entry.action != lddw_pkg::ACT_TICK);
      if (byte_index == 5'd0) begin
        // start condition: clock low, data high, clock high, data low
        case (phase_count[1:0])
          2'd0:    clk_level_next  = 1'b0;
          2'd1:    data_level_next = 1'b1;
          2'd2:    clk_level_next  = 1'b1;
          default: data_level_next = 1'b0;
        endcase
      end else if (byte_index > bytes_in_frame) begin
        // stop condition: clock low, data low, clock high, data high
        case (phase_count[1:0])
          2'd0:    clk_level_next  = 1'b0;
          2'd1:    data_level_next = 1'b0;
          2'd2:    clk_level_next  = 1'b1;
          default: data_level_next = 1'b1;
        endcase
      end else begin
        // data bit: clock low, drive bit, clock high and shift
        seg_len = 5'd24;
        if (phase_count == 5'd0) begin
          shift_byte_next = frame_byte;
        end
        case (bit_step)
          2'd0:    clk_level_next = 1'b0;
          2'd1:    data_level_next = shift_byte[0];
          default: begin
            clk_level_next  = 1'b1;
            shift_byte_next = {1'b0, shift_byte[7:1]};
          end
        endcase
      end

      bit_step_next    = (bit_step == 2'd2) ? 2'd0 : bit_step + 2'd1;
      phase_count_next = phase_inc;
      if (phase_inc >= seg_len) begin
        phase_count_next = 5'd0;
        bit_step_next    = 2'd0;
        byte_index_next  = byte_inc;
        if (byte_inc > bytes_in_frame + 5'd1) begin
          byte_index_next  = 5'd0;
          frame_index_next = frame_inc;
          if (frame_inc >= frame_total) begin
            frame_index_next = 3'd0;
            job_kind_next    = lddw_pkg::ACT_TICK;
            busy_flag_next   = 1'b0;
            done_next        = 1'b1;
          end
        end
      end
    end
  end

  // Hold control state, configuration and the result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_mode_cmd  <= 8'h44;
      auto_mode_cmd   <= 8'h40;
      display_on_cmd  <= 8'h8f;
      display_off_cmd <= 8'h80;
      digit_addr[0]   <= 8'hc0;
      digit_addr[1]   <= 8'hc1;
      digit_addr[2]   <= 8'hc2;
      digit_addr[3]   <= 8'hc3;
      job_kind        <= lddw_pkg::ACT_TICK;
      frame_index     <= 3'd0;
      byte_index      <= 5'd0;
      phase_count     <= 5'd0;
      bit_step        <= 2'd0;
      shift_byte      <= 8'h00;
      held_addr       <= 8'h00;
      held_value      <= 8'h00;
      clk_level       <= 1'b1;
      data_level      <= 1'b1;
      busy_flag       <= 1'b0;
      out_valid       <= 1'b0;
      clk_out         <= 1'b1;
      data_out        <= 1'b1;
      busy_res        <= 1'b0;
      rejected        <= 1'b0;
      seq_done        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          lddw_pkg::REG_FIXED_MODE:  fixed_mode_cmd  <= cfg_data;
          lddw_pkg::REG_AUTO_MODE:   auto_mode_cmd   <= cfg_data;
          lddw_pkg::REG_DISPLAY_ON:  display_on_cmd  <= cfg_data;
          lddw_pkg::REG_DISPLAY_OFF: display_off_cmd <= cfg_data;
          lddw_pkg::REG_DIGIT1_ADDR: digit_addr[0]   <= cfg_data;
          lddw_pkg::REG_DIGIT2_ADDR: digit_addr[1]   <= cfg_data;
          lddw_pkg::REG_DIGIT3_ADDR: digit_addr[2]   <= cfg_data;
          lddw_pkg::REG_DIGIT4_ADDR: digit_addr[3]   <= cfg_data;
          default:                   fixed_mode_cmd  <= fixed_mode_cmd;
        endcase
      end
      if (start && q_entry.action == lddw_pkg::ACT_WRITE) begin
        held_addr  <= q_entry.data[0];
        held_value <= q_entry.data[1];
      end
      job_kind    <= job_kind_next;
      frame_index <= frame_index_next;
      byte_index  <= byte_index_next;
      phase_count <= phase_count_next;
      bit_step    <= bit_step_next;
      shift_byte  <= shift_byte_next;
      clk_level   <= clk_level_next;
      data_level  <= data_level_next;
      busy_flag   <= busy_flag_next;
      if (q_rd) begin
        out_valid <= 1'b1;
        clk_out   <= clk_level_next;
        data_out  <= data_level_next;
        busy_res  <= busy_flag_next;
        rejected  <= rejected_next;
        seq_done  <= done_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the segment bytes of a show-number request
  always_ff @(posedge clk) begin
    if (start && q_entry.action == lddw_pkg::ACT_SHOW) begin
      digit_segments <= q_entry.data;
    end
  end

  assign empty = !out_valid;

  `LDDW_ASSERT_IMPLY(a_done_idle, out_valid && seq_done, !busy_res)
  `LDDW_ASSERT_ALWAYS(a_busy_job, busy_flag == (job_kind != lddw_pkg::ACT_TICK))
  `LDDW_ASSERT_ALWAYS(a_phase_range, phase_count < 5'd24 && bit_step != 2'd3)

endmodule

>>> sv/led_driver_two_wire_display_writer.sv
// Two-wire LED driver writer. Each request pushed in returns exactly one result, in order:
// the clock and data pin levels after that item, busy, a rejected flag and a sequence-done
// flag. Action 0 is a tick that advances the bus by one pin phase; actions 1 to 3 (show
// number, write byte, clear) start a frame sequence when idle and are rejected, but still
// advance one phase, when busy. The block takes one request per clock cycle while full is
// low and results are popped. Requests pass two front stages that split off the thousands
// and the hundreds digit (tens and units follow the second stage), an eight-entry queue
// that separates them from the bus sequencer, and the sequencer's result register, which
// drains one result per cycle while pop is held. Push sees full only when eight requests
// are in flight between the input and the result register. Configuration writes go to
// registers 0..7 (command bytes, then the four digit addresses) and belong in idle periods.
module led_driver_two_wire_display_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [15:0] number,
  input  logic [7:0]  target_addr,
  input  logic [7:0]  seg_value,
  output logic        empty,
  input  logic        pop,
  output logic        clk_out,
  output logic        data_out,
  output logic        busy_res,
  output logic        rejected,
  output logic        seq_done
);

  logic              q_wr;
  logic              q_rd;
  logic              q_empty;
  lddw_pkg::entry_t  q_wr_entry;
  lddw_pkg::entry_t  q_rd_entry;

  // Accept and classify requests
  lddw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .number      (number),
    .target_addr (target_addr),
    .seg_value   (seg_value),
    .deq         (q_rd),
    .q_wr        (q_wr),
    .q_entry     (q_wr_entry)
  );

  // Decouple front and back
  lddw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr),
    .wr_entry (q_wr_entry),
    .rd_en    (q_rd),
    .empty    (q_empty),
    .rd_entry (q_rd_entry)
  );

  // Drive the bus one phase per request
  lddw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_entry   (q_rd_entry),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .clk_out   (clk_out),
    .data_out  (data_out),
    .busy_res  (busy_res),
    .rejected  (rejected),
    .seq_done  (seq_done)
  );

endmodule

>>> test/led_driver_two_wire_display_writer_test.sv
module led_driver_two_wire_display_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Segment patterns of the decimal digits, 0 through 9
  localparam logic [7:0] DIGIT_PATTERN [10] = '{
    8'h3f, 8'h18, 8'h76, 8'h7c, 8'h59, 8'h6d, 8'h6f, 8'h38, 8'h7f, 8'h79
  };
  localparam int SHOW_FRAMES  = 6;
  localparam int OTHER_FRAMES = 3;
  localparam int EDGE_PHASES  = 4;
  localparam int BYTE_PHASES  = 24;

  typedef struct packed {
    logic clk_pin;
    logic data_pin;
    logic busy;
    logic rejected;
    logic done;
  } pin_levels_t;

  // Tracks the bus sequencer and holds the pin levels each request must produce
  class bus_pin_model;
    logic [7:0]            regs [8];
    lddw_pkg::action_t     job;
    int                    frame_idx;
    int                    byte_idx;
    int                    phase_cnt;
    logic [7:0]            shifter;
    logic [7:0]            digit_seg [4];
    logic [7:0]            held_addr;
    logic [7:0]            held_value;
    logic                  clk_lvl;
    logic                  data_lvl;
    logic                  busy;
    pin_levels_t           pin_levels_due [$];
    int                    pin_mismatches;
    int                    results_seen;

    function new();
      regs[lddw_pkg::REG_FIXED_MODE]  = 8'h44;
      regs[lddw_pkg::REG_AUTO_MODE]   = 8'h40;
      regs[lddw_pkg::REG_DISPLAY_ON]  = 8'h8f;
      regs[lddw_pkg::REG_DISPLAY_OFF] = 8'h80;
      regs[lddw_pkg::REG_DIGIT1_ADDR] = 8'hc0;
      regs[lddw_pkg::REG_DIGIT2_ADDR] = 8'hc1;
      regs[lddw_pkg::REG_DIGIT3_ADDR] = 8'hc2;
      regs[lddw_pkg::REG_DIGIT4_ADDR] = 8'hc3;
      job = lddw_pkg::ACT_TICK;
      frame_idx = 0;
      byte_idx = 0;
      phase_cnt = 0;
      shifter = '0;
      foreach (digit_seg[i]) digit_seg[i] = '0;
      held_addr = '0;
      held_value = '0;
      clk_lvl = 1'b1;
      data_lvl = 1'b1;
      busy = 1'b0;
      pin_mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_reg(lddw_pkg::reg_index_t idx, logic [7:0] val);
      regs[idx] = val;
    endfunction

    function int frames();
      return (job == lddw_pkg::ACT_SHOW) ? SHOW_FRAMES : OTHER_FRAMES;
    endfunction

    function int frame_bytes();
      if (frame_idx == 0 || frame_idx + 1 >= frames()) return 1;
      return (job == lddw_pkg::ACT_CLEAR) ? 1 + lddw_pkg::CLEAR_BYTES : 2;
    endfunction

    // Byte k of the current frame (k counts from 1)
    function logic [7:0] frame_byte(int k);
      int d;
      if (frame_idx == 0)
        return (job == lddw_pkg::ACT_CLEAR) ? regs[lddw_pkg::REG_AUTO_MODE]
                                            : regs[lddw_pkg::REG_FIXED_MODE];
      if (frame_idx + 1 >= frames())
        return (job == lddw_pkg::ACT_CLEAR) ? regs[lddw_pkg::REG_DISPLAY_OFF]
                                            : regs[lddw_pkg::REG_DISPLAY_ON];
      d = (frame_idx - 1) & 3;
      if (job == lddw_pkg::ACT_SHOW)
        return (k == 1) ? regs[int'(lddw_pkg::REG_DIGIT1_ADDR) + d] : digit_seg[d];
      if (job == lddw_pkg::ACT_WRITE)
        return (k == 1) ? held_addr : held_value;
      return (k == 1) ? lddw_pkg::CLEAR_ADDR : 8'h00;
    endfunction

    // Advance one pin phase; return 1 when the final stop completes
    function bit step_pins();
      int nb;
      int seglen;
      int p;
      nb = frame_bytes();
      p = phase_cnt;
      if (byte_idx == 0) begin
        // start condition
        seglen = EDGE_PHASES;
        case (p)
          0: clk_lvl = 1'b0;
          1: data_lvl = 1'b1;
          2: clk_lvl = 1'b1;
          default: data_lvl = 1'b0;
        endcase
      end else if (byte_idx > nb) begin
        // stop condition
        seglen = EDGE_PHASES;
        case (p)
          0: clk_lvl = 1'b0;
          1: data_lvl = 1'b0;
          2: clk_lvl = 1'b1;
          default: data_lvl = 1'b1;
        endcase
      end else begin
        // one byte, LSB first, three phases per bit
        seglen = BYTE_PHASES;
        if (p == 0) shifter = frame_byte(byte_idx);
        case (p % 3)
          0: clk_lvl = 1'b0;
          1: data_lvl = shifter[0];
          default: begin
            clk_lvl = 1'b1;
            shifter = shifter >> 1;
          end
        endcase
      end
      phase_cnt = p + 1;
      if (phase_cnt >= seglen) begin
        phase_cnt = 0;
        byte_idx++;
        if (byte_idx > nb + 1) begin
          byte_idx = 0;
          frame_idx++;
          if (frame_idx >= frames()) begin
            frame_idx = 0;
            job = lddw_pkg::ACT_TICK;
            busy = 1'b0;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    // Apply one accepted request and queue the pin levels it yields
    function void note_request(lddw_pkg::action_t act, logic [15:0] num, logic [7:0] addr,
                               logic [7:0] value);
      pin_levels_t r;
      int n;
      r = '0;
      if (busy) begin
        r.rejected = (act != lddw_pkg::ACT_TICK);
        r.done = step_pins();
      end else if (act != lddw_pkg::ACT_TICK) begin
        job = act;
        frame_idx = 0;
        byte_idx = 0;
        phase_cnt = 0;
        busy = 1'b1;
        if (act == lddw_pkg::ACT_SHOW) begin
          n = (num > lddw_pkg::NUM_CAP) ? int'(lddw_pkg::NUM_CAP) : int'(num);
          digit_seg[0] = DIGIT_PATTERN[n / 1000] | lddw_pkg::DP_BIT;
          digit_seg[1] = DIGIT_PATTERN[(n / 100) % 10] | lddw_pkg::DP_BIT;
          digit_seg[2] = DIGIT_PATTERN[(n / 10) % 10];
          digit_seg[3] = DIGIT_PATTERN[n % 10];
        end else if (act == lddw_pkg::ACT_WRITE) begin
          held_addr = addr;
          held_value = value;
        end
      end
      r.clk_pin = clk_lvl;
      r.data_pin = data_lvl;
      r.busy = busy;
      pin_levels_due.push_back(r);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (want !== got) begin
        pin_mismatches++;
        if (pin_mismatches <= 10)
          $display("result %0d: %s expected %b, got %b", results_seen, name, want, got);
      end
    endfunction

    function void check_pins(pin_levels_t got);
      pin_levels_t want;
      results_seen++;
      if (pin_levels_due.size() == 0) begin
        pin_mismatches++;
        if (pin_mismatches <= 10)
          $display("result %0d: arrived with nothing pending, got %b", results_seen, got);
        return;
      end
      want = pin_levels_due.pop_front();
      compare_field("clk_out", want.clk_pin, got.clk_pin);
      compare_field("data_out", want.data_pin, got.data_pin);
      compare_field("busy_res", want.busy, got.busy);
      compare_field("rejected", want.rejected, got.rejected);
      compare_field("seq_done", want.done, got.done);
    endfunction

    function int pending();
      return pin_levels_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = lddw_pkg::REG_FIXED_MODE;
  logic [7:0]  cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  action = lddw_pkg::ACT_TICK;
  logic [15:0] number = '0;
  logic [7:0]  target_addr = '0;
  logic [7:0]  seg_value = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        clk_out;
  logic        data_out;
  logic        busy_res;
  logic        rejected;
  logic        seq_done;

  bus_pin_model pin_model = new();
  bit           steady_in = 1'b0;

  led_driver_two_wire_display_writer i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .action      (action),
    .number      (number),
    .target_addr (target_addr),
    .seg_value   (seg_value),
    .empty       (empty),
    .pop         (pop),
    .clk_out     (clk_out),
    .data_out    (data_out),
    .busy_res    (busy_res),
    .rejected    (rejected),
    .seq_done    (seq_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [15:0] pick_number();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, lddw_pkg::NUM_CAP));
  endfunction

  function automatic lddw_pkg::action_t pick_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return lddw_pkg::ACT_SHOW;
    if (r < 80) return lddw_pkg::ACT_WRITE;
    return lddw_pkg::ACT_CLEAR;
  endfunction

  // Check every popped result against the oldest pending one
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      pin_model.check_pins(pin_levels_t'({clk_out, data_out, busy_res, rejected, seq_done}));
  end

  // Pop side: random stalls, with stretches of none
  initial begin
    int  stall;
    bit  steady;
    stall = 0;
    steady = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) steady = !steady;
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if (!steady) stall = pick_gap();
      end
    end
  end

  // Push one request, after a random gap, and hold it until accepted
  task automatic send_item(lddw_pkg::action_t act, logic [15:0] num, logic [7:0] addr,
                           logic [7:0] value);
    int gap;
    if ($urandom_range(0, 149) == 0) steady_in = !steady_in;
    gap = steady_in ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    action <= act;
    number <= num;
    target_addr <= addr;
    seg_value <= value;
    do @(posedge clk); while (full);
    pin_model.note_request(act, num, addr, value);
  endtask

  task automatic tick();
    send_item(lddw_pkg::ACT_TICK, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Tick until the current sequence has finished
  task automatic run_out();
    while (pin_model.busy) tick();
  endtask

  // Drop push and wait until every result has been popped
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    while (pin_model.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write all registers: 0 all zeros, 1 all ones, otherwise random
  task automatic load_config(int style);
    logic [7:0] val;
    for (int i = 0; i < 8; i++) begin
      val = (style == 0) ? 8'h00 : (style == 1) ? 8'hff : 8'($urandom);
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= lddw_pkg::reg_index_t'(i);
      cfg_data <= val;
      pin_model.set_reg(lddw_pkg::reg_index_t'(i), val);
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly complete sequences; a few requests land while busy
  task automatic random_items(int count);
    int                 issued;
    int                 r;
    lddw_pkg::action_t  act;
    issued = 0;
    while (issued < count) begin
      r = $urandom_range(0, 99);
      if (!pin_model.busy) begin
        if (r < 85) begin
          issued++;
          send_item(pick_request(), pick_number(), 8'($urandom), 8'($urandom));
        end else begin
          tick();
        end
      end else begin
        act = (r < 3) ? pick_request() : lddw_pkg::ACT_TICK;
        issued++;
        send_item(act, pick_number(), 8'($urandom), 8'($urandom));
      end
    end
    run_out();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Idle ticks, then requests dropped while a sequence runs
    tick();
    tick();
    send_item(lddw_pkg::ACT_SHOW, 16'h0000, 8'h00, 8'h00);
    repeat (5) tick();
    send_item(lddw_pkg::ACT_WRITE, 16'h1234, 8'h5a, 8'ha5);
    tick();
    send_item(lddw_pkg::ACT_CLEAR, 16'h0000, 8'hff, 8'hff);
    send_item(lddw_pkg::ACT_SHOW, 16'hffff, 8'h00, 8'h00);
    run_out();

    // Clamp and its boundary, field extremes, clear
    send_item(lddw_pkg::ACT_SHOW, 16'hffff, 8'h00, 8'hff);
    run_out();
    send_item(lddw_pkg::ACT_SHOW, 16'(lddw_pkg::NUM_CAP + 1), 8'h00, 8'h00);
    run_out();
    send_item(lddw_pkg::ACT_WRITE, 16'h0000, 8'hff, 8'h00);
    run_out();
    send_item(lddw_pkg::ACT_WRITE, 16'hffff, 8'h00, 8'hff);
    run_out();
    send_item(lddw_pkg::ACT_CLEAR, 16'h0000, 8'h00, 8'h00);
    run_out();
    tick();

    for (int style = 0; style < 3; style++) begin
      drain();
      load_config(style);
      random_items(285);
    end

    @(negedge clk);
    push <= 1'b0;
    while (pin_model.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pin_model.pin_mismatches == 0 && pin_model.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/lddw_pkg.sv
sv/lddw_queue.sv
sv/lddw_front.sv
sv/lddw_back.sv
sv/led_driver_two_wire_display_writer.sv
test/led_driver_two_wire_display_writer_test.sv
